// ===== sv/gnts_pkg.sv =====
package gnts_pkg;

    localparam int SPEED_BITS_DEF = 20;
    localparam int STEP_BITS_DEF  = 16;
    localparam int FRAC_BITS      = 5;
    localparam int JUMP_LIMIT     = 35;
    localparam int SPD_BITS       = 16;
    localparam int CFG_IDX_W      = 3;

    localparam int RST_MAX_RPM      = 128000;
    localparam int RST_MIN_STEPS    = 0;
    localparam int RST_MAX_STEPS    = 4095;
    localparam int RST_FAST_SPEED   = 3000;
    localparam int RST_NORMAL_SPEED = 800;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_RPM      = 3'd0,
        REG_MIN_STEPS    = 3'd1,
        REG_MAX_STEPS    = 3'd2,
        REG_FAST_SPEED   = 3'd3,
        REG_NORMAL_SPEED = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_V,
        ST_SUM,
        ST_DIV,
        ST_EVAL,
        ST_OUT
    } state_t;

endpackage

// ===== sv/gnts_mul.sv =====
module gnts_mul #(
    parameter int A_W = 25,
    parameter int B_W = 17
) (
    input  logic                        clk,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   p
);

    logic signed [A_W+B_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ===== sv/gnts_div.sv =====
module gnts_div #(
    parameter int N_W = 42,
    parameter int D_W = 25,
    parameter int Q_W = 17
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [Q_W-1:0] quo
);

    localparam int SH_W  = D_W + Q_W - 1;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [N_W-1:0]   rem_reg, rem_next;
    logic [SH_W-1:0]  dsh_reg, dsh_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [N_W-1:0]   dsh_ext;
    logic             fits;

    assign dsh_ext = N_W'(dsh_reg);
    assign fits    = (rem_reg >= dsh_ext);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = SH_W'(den) << (Q_W - 1);
            quo_next  = '0;
            cnt_next  = CNT_W'(Q_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_ext;
            end
            quo_next = {quo_reg[Q_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/gauge_needle_target_smoother.sv =====
// Gauge needle target smoother.
// Input channel (in_valid/in_ready): one word holds a speed reading in 1/16 rpm,
// an invalid flag and the present motor step position.
// Output channel (out_valid/out_ready): one word per input word with the step
// target of the smoothed speed, the chosen step rate and the jump flag.
// Config port: cfg_we writes cfg_data into register cfg_index (0 max_rpm,
// 1 min_steps, 2 max_steps, 3 fast_speed, 4 normal_speed); other indexes ignored.
// Each word runs the speed-to-steps map twice (raw reading, then smoothed
// value) through one shared multiplier and one restoring divider that yields
// one quotient bit per cycle. Each map steps through MUL_LO, MUL_V, SUM, DIV
// and EVAL, and the second pass then goes on to OUT. No new word is accepted
// before the last one is finished: in_ready is high only while the sequencer
// is idle.
// A finished word is held in the output register; if the previous word was not
// yet taken, the sequencer waits there until out_ready frees the register.
// Reset loads the register defaults, clears the smoothed speed and drops
// out_valid.
module gauge_needle_target_smoother #(
    parameter int SPEED_BITS = gnts_pkg::SPEED_BITS_DEF,
    parameter int STEP_BITS  = gnts_pkg::STEP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gnts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [((SPEED_BITS-1) > STEP_BITS ? ((SPEED_BITS-1) > gnts_pkg::SPD_BITS ?
                   (SPEED_BITS-1) : gnts_pkg::SPD_BITS) : (STEP_BITS > gnts_pkg::SPD_BITS ?
                   STEP_BITS : gnts_pkg::SPD_BITS))-1:0] cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SPEED_BITS-1:0]        speed_reading,
    input  logic                                reading_invalid,
    input  logic signed [STEP_BITS-1:0]         motor_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [STEP_BITS-1:0]         target_steps,
    output logic [gnts_pkg::SPD_BITS-1:0]       move_speed,
    output logic                                jumped
);

    localparam int RPM_BITS    = SPEED_BITS - 1;
    localparam int SMOOTH_BITS = RPM_BITS + gnts_pkg::FRAC_BITS;
    localparam int A_W         = SMOOTH_BITS + 1;
    localparam int B_W         = STEP_BITS + 1;
    localparam int PROD_W      = A_W + B_W;
    localparam int T_W         = PROD_W + 1;
    localparam int N_W         = T_W + 1;
    localparam int D_W         = SMOOTH_BITS + 1;
    localparam int Q_W         = STEP_BITS + 1;
    localparam int SPD_W       = gnts_pkg::SPD_BITS;

    gnts_pkg::state_t state_reg, state_next;

    logic [RPM_BITS-1:0]           max_rpm_reg;
    logic signed [STEP_BITS-1:0]   min_steps_reg;
    logic signed [STEP_BITS-1:0]   max_steps_reg;
    logic [SPD_W-1:0]              fast_speed_reg;
    logic [SPD_W-1:0]              normal_speed_reg;

    logic [SMOOTH_BITS-1:0]        smooth_reg, smooth_next;
    logic [SMOOTH_BITS-1:0]        cfx_reg, cfx_next;
    logic [SMOOTH_BITS-1:0]        v_reg, v_next;
    logic signed [STEP_BITS-1:0]   pos_reg, pos_next;
    logic                          pass_reg, pass_next;
    logic                          jump_reg, jump_next;
    logic signed [PROD_W-1:0]      acc_reg, acc_next;
    logic                          neg_reg, neg_next;
    logic signed [STEP_BITS-1:0]   tgt_reg, tgt_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [STEP_BITS-1:0]   out_tgt_reg, out_tgt_next;
    logic [SPD_W-1:0]              out_spd_reg, out_spd_next;
    logic                          out_jmp_reg, out_jmp_next;

    logic [RPM_BITS-1:0]           clamped;
    logic [SMOOTH_BITS-1:0]        full;
    logic signed [A_W-1:0]         mul_a;
    logic signed [B_W-1:0]         mul_b;
    logic signed [B_W-1:0]         span;
    logic signed [PROD_W-1:0]      prod;
    logic signed [T_W-1:0]         t_sum;
    logic [T_W-1:0]                t_mag;
    logic [N_W-1:0]                div_num;
    logic [D_W-1:0]                div_den;
    logic                          div_start;
    logic                          div_done;
    logic [Q_W-1:0]                div_quo;
    logic signed [Q_W:0]           q_signed;
    logic signed [STEP_BITS-1:0]   map_steps;
    logic signed [STEP_BITS:0]     step_gap;
    logic                          jump_now;
    logic signed [SMOOTH_BITS:0]   sdiff;
    logic signed [SMOOTH_BITS:0]   supd;
    logic [SMOOTH_BITS-1:0]        snew;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rpm_reg      <= RPM_BITS'(gnts_pkg::RST_MAX_RPM);
            min_steps_reg    <= STEP_BITS'(gnts_pkg::RST_MIN_STEPS);
            max_steps_reg    <= STEP_BITS'(gnts_pkg::RST_MAX_STEPS);
            fast_speed_reg   <= SPD_W'(gnts_pkg::RST_FAST_SPEED);
            normal_speed_reg <= SPD_W'(gnts_pkg::RST_NORMAL_SPEED);
        end
        else if (cfg_we)
        begin
            case (gnts_pkg::cfg_idx_t'(cfg_index))
                gnts_pkg::REG_MAX_RPM:      max_rpm_reg      <= cfg_data[RPM_BITS-1:0];
                gnts_pkg::REG_MIN_STEPS:    min_steps_reg    <= cfg_data[STEP_BITS-1:0];
                gnts_pkg::REG_MAX_STEPS:    max_steps_reg    <= cfg_data[STEP_BITS-1:0];
                gnts_pkg::REG_FAST_SPEED:   fast_speed_reg   <= cfg_data[SPD_W-1:0];
                gnts_pkg::REG_NORMAL_SPEED: normal_speed_reg <= cfg_data[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // input clamp
    always_comb
    begin
        if (reading_invalid || speed_reading[SPEED_BITS-1])
        begin
            clamped = '0;
        end
        else if (speed_reading[RPM_BITS-1:0] > max_rpm_reg)
        begin
            clamped = max_rpm_reg;
        end
        else
        begin
            clamped = speed_reading[RPM_BITS-1:0];
        end
    end

    assign full = {max_rpm_reg, {gnts_pkg::FRAC_BITS{1'b0}}};
    assign span = $signed({max_steps_reg[STEP_BITS-1], max_steps_reg})
                - $signed({min_steps_reg[STEP_BITS-1], min_steps_reg});

    // shared multiplier: full*lo, then v*(hi-lo)
    always_comb
    begin
        if (state_reg == gnts_pkg::ST_MUL_LO)
        begin
            mul_a = $signed({1'b0, full});
            mul_b = $signed({min_steps_reg[STEP_BITS-1], min_steps_reg});
        end
        else
        begin
            mul_a = $signed({1'b0, v_reg});
            mul_b = span;
        end
    end

    gnts_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign t_sum   = T_W'(acc_reg) + T_W'(prod);
    assign t_mag   = t_sum[T_W-1] ? T_W'(-t_sum) : T_W'(t_sum);
    assign div_num = {t_mag, 1'b0} + N_W'(full);
    assign div_den = {full, 1'b0};
    assign div_start = (state_reg == gnts_pkg::ST_SUM);

    gnts_div #(
        .N_W (N_W),
        .D_W (D_W),
        .Q_W (Q_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign q_signed  = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign map_steps = (max_rpm_reg == '0) ? min_steps_reg : q_signed[STEP_BITS-1:0];
    assign step_gap  = $signed({map_steps[STEP_BITS-1], map_steps})
                     - $signed({pos_reg[STEP_BITS-1], pos_reg});
    assign jump_now  = (step_gap > $signed((STEP_BITS+1)'(gnts_pkg::JUMP_LIMIT)))
                    || (step_gap < -$signed((STEP_BITS+1)'(gnts_pkg::JUMP_LIMIT)));
    assign sdiff     = $signed({1'b0, cfx_reg}) - $signed({1'b0, smooth_reg});
    assign supd      = $signed({1'b0, smooth_reg}) + (sdiff >>> 2);
    assign snew      = jump_now ? cfx_reg : supd[SMOOTH_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        smooth_next    = smooth_reg;
        cfx_next       = cfx_reg;
        v_next         = v_reg;
        pos_next       = pos_reg;
        pass_next      = pass_reg;
        jump_next      = jump_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        tgt_next       = tgt_reg;
        out_valid_next = out_valid_reg;
        out_tgt_next   = out_tgt_reg;
        out_spd_next   = out_spd_reg;
        out_jmp_next   = out_jmp_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            gnts_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cfx_next   = {clamped, {gnts_pkg::FRAC_BITS{1'b0}}};
                    v_next     = {clamped, {gnts_pkg::FRAC_BITS{1'b0}}};
                    pos_next   = motor_position;
                    pass_next  = 1'b0;
                    state_next = gnts_pkg::ST_MUL_LO;
                end
            end
            gnts_pkg::ST_MUL_LO:
            begin
                state_next = gnts_pkg::ST_MUL_V;
            end
            gnts_pkg::ST_MUL_V:
            begin
                acc_next   = prod;
                state_next = gnts_pkg::ST_SUM;
            end
            gnts_pkg::ST_SUM:
            begin
                neg_next   = t_sum[T_W-1];
                state_next = gnts_pkg::ST_DIV;
            end
            gnts_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = gnts_pkg::ST_EVAL;
                end
            end
            gnts_pkg::ST_EVAL:
            begin
                if (!pass_reg)
                begin
                    jump_next   = jump_now;
                    smooth_next = snew;
                    v_next      = (snew > full) ? full : snew;
                    pass_next   = 1'b1;
                    state_next  = gnts_pkg::ST_MUL_LO;
                end
                else
                begin
                    tgt_next   = map_steps;
                    state_next = gnts_pkg::ST_OUT;
                end
            end
            gnts_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_tgt_next   = tgt_reg;
                    out_spd_next   = jump_reg ? fast_speed_reg : normal_speed_reg;
                    out_jmp_next   = jump_reg;
                    state_next     = gnts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gnts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gnts_pkg::ST_IDLE;
            smooth_reg    <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            smooth_reg    <= smooth_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cfx_reg     <= cfx_next;
        v_reg       <= v_next;
        pos_reg     <= pos_next;
        jump_reg    <= jump_next;
        acc_reg     <= acc_next;
        neg_reg     <= neg_next;
        tgt_reg     <= tgt_next;
        out_tgt_reg <= out_tgt_next;
        out_spd_reg <= out_spd_next;
        out_jmp_reg <= out_jmp_next;
    end

    assign out_valid    = out_valid_reg;
    assign target_steps = out_tgt_reg;
    assign move_speed   = out_spd_reg;
    assign jumped       = out_jmp_reg;

endmodule
